### rtl/rau_pkg.sv
// shared constants, codes, item and control types of the rational arithmetic unit
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int DBL_BITS  = 2 * WORD_BITS;
    localparam int K_BITS    = $clog2(DBL_BITS);
    localparam int MUL_STEPS = 3;
    localparam int DIV_STEPS = DBL_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_NEG = 3'd4,
        MODE_RED = 3'd5,
        MODE_CMP = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic               less_flag;
        logic               equal_flag;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic gcd_done;
    } t_sts;

endpackage

### rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: controller and datapath
//
//  channel  direction  payload  handshake
//  in       input      t_in     i_in_valid / o_in_stall
//  out      output     t_out    o_out_valid / i_out_stall
//
// a fraction item passes the shared multiplier, the binary gcd loop and the
// one-bit-per-cycle divider, whose work sets how long the item takes
// compare, zero-denominator and unused mode items skip the gcd loop and the divider
// synchronous active-low reset clears the controller and the output valid
// the output register lets the next item be accepted while a result waits
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  logic i_in_valid,
    output logic o_in_stall,
    output t_out o_out,
    output logic o_out_valid,
    input  logic i_out_stall
);

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rau_dp u_dp (
        .i_clk (i_clk),
        .i_in  (i_in),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_out (o_out)
    );

endmodule

### rtl/rau_ctrl.sv
// sequencing state machine of the rational arithmetic unit
module rau_ctrl import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_MUL:  o_cmd.mul_en = 1'b1;
            S_COMB: o_cmd.comb = 1'b1;
            S_GCD: begin
                if (!i_sts.skip) begin
                    o_cmd.div_init = i_sts.gcd_done;
                    o_cmd.gcd_step = !i_sts.gcd_done;
                end
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_FIN:  o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CNT_BITS'(MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_COMB;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_COMB: r_state <= S_GCD;
                S_GCD: begin
                    r_cnt <= '0;
                    if (i_sts.skip) begin
                        r_state <= S_FIN;
                    end else if (i_sts.gcd_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/rau_dp.sv
// datapath: shared multiplier, combine, binary gcd, dual restoring divider, output register
module rau_dp import rau_pkg::*; (
    input  logic i_clk,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out
);

    localparam int W = WORD_BITS;
    localparam int D = DBL_BITS;
    localparam logic [D-1:0] LIM = {{(D-W+1){1'b0}}, {(W-1){1'b1}}};

    t_mode          r_mode;
    logic           r_ann, r_adn, r_bnn, r_bdn;
    logic [W-1:0]   r_anm, r_adm, r_bnm, r_bdm;
    logic [D-1:0]   r_p1, r_p2, r_p3;
    logic           r_nn, r_dn, r_frac;
    t_status        r_status;
    logic           r_less, r_equal;
    logic [D-1:0]   r_nm, r_dm;
    logic [D-1:0]   r_x, r_y;
    logic [K_BITS-1:0] r_k;
    logic [D-1:0]   r_g;
    logic [D-1:0]   r_qn, r_qd, r_rn, r_rd;
    t_out           r_out;

    logic [W-1:0]   w_an, w_ad, w_bn, w_bd;
    logic [W-1:0]   op_x, op_y;
    logic [D-1:0]   prod;

    logic           s_n1, s_n2, s_sign;
    logic [D-1:0]   s_mag;
    logic           c_nn, c_dn, c_err, c_frac;
    logic [D-1:0]   c_nm, c_dm;
    logic signed [D:0] lv, rv;

    logic [D:0]     tn, td, gx;
    logic           f_neg, f_ovf;
    logic [D-1:0]   f_sn;
    logic signed [W-1:0] f_num;
    t_out           f_out;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_an = i_in.a_num[W-1:0];
    assign w_ad = i_in.a_den[W-1:0];
    assign w_bn = i_in.b_num[W-1:0];
    assign w_bd = i_in.b_den[W-1:0];

    // operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            2'd0: begin
                op_x = r_anm;
                op_y = (r_mode == MODE_MUL) ? r_bnm : r_bdm;
            end
            2'd1: begin
                op_x = r_bnm;
                op_y = r_adm;
            end
            default: begin
                op_x = r_adm;
                op_y = (r_mode == MODE_DIV) ? r_bnm : r_bdm;
            end
        endcase
    end

    assign prod = D'(op_x) * D'(op_y);

    // signed-magnitude sum of the cross products
    always_comb begin
        s_n1 = r_ann ^ r_bdn;
        s_n2 = (r_bnn ^ r_adn) ^ (r_mode == MODE_SUB);
        if (s_n1 == s_n2) begin
            s_sign = s_n1;
            s_mag  = r_p1 + r_p2;
        end else if (r_p1 >= r_p2) begin
            s_sign = s_n1;
            s_mag  = r_p1 - r_p2;
        end else begin
            s_sign = s_n2;
            s_mag  = r_p2 - r_p1;
        end
    end

    always_comb begin
        c_nn   = 1'b0;
        c_nm   = '0;
        c_dn   = 1'b0;
        c_dm   = '0;
        c_err  = 1'b0;
        c_frac = 1'b0;
        case (r_mode)
            MODE_ADD, MODE_SUB: begin
                c_nn   = s_sign;
                c_nm   = s_mag;
                c_dn   = r_adn ^ r_bdn;
                c_dm   = r_p3;
                c_err  = (r_adm == '0) || (r_bdm == '0);
                c_frac = 1'b1;
            end
            MODE_MUL: begin
                c_nn   = r_ann ^ r_bnn;
                c_nm   = r_p1;
                c_dn   = r_adn ^ r_bdn;
                c_dm   = r_p3;
                c_err  = (r_adm == '0) || (r_bdm == '0);
                c_frac = 1'b1;
            end
            MODE_DIV: begin
                c_nn   = r_ann ^ r_bdn;
                c_nm   = r_p1;
                c_dn   = r_adn ^ r_bnn;
                c_dm   = r_p3;
                c_err  = (r_adm == '0) || (r_bdm == '0) || (r_bnm == '0);
                c_frac = 1'b1;
            end
            MODE_NEG, MODE_RED: begin
                c_nn   = (r_mode == MODE_NEG) ? !r_ann : r_ann;
                c_nm   = D'(r_anm);
                c_dn   = r_adn;
                c_dm   = D'(r_adm);
                c_err  = (r_adm == '0);
                c_frac = 1'b1;
            end
            MODE_CMP: c_err = (r_adm == '0) || (r_bdm == '0);
            default: c_err = 1'b0;
        endcase
    end

    // exact signed cross products for compare
    always_comb begin
        lv = (r_ann ^ r_bdn) ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
        rv = (r_bnn ^ r_adn) ? -$signed({1'b0, r_p2}) : $signed({1'b0, r_p2});
    end

    assign o_sts.skip     = (r_status != ST_OK) || !r_frac;
    assign o_sts.gcd_done = (r_x == '0) || (r_y == '0);

    assign gx = {1'b0, r_g};
    assign tn = {r_rn, r_qn[D-1]};
    assign td = {r_rd, r_qd[D-1]};

    // final normalise, overflow check and packing
    always_comb begin
        f_neg = (r_qn != '0) && (r_nn != r_dn);
        f_ovf = (r_qd > LIM) || (r_qn > (LIM + D'(f_neg)));
        f_sn  = f_neg ? (~r_qn + 1'b1) : r_qn;
        f_num = $signed(f_sn[W-1:0]);
        f_out = '0;
        if (r_frac && (r_status == ST_OK)) begin
            if (f_ovf) begin
                f_out.status = ST_OVERFLOW;
            end else begin
                f_out.result_num = 32'(f_num);
                f_out.result_den = 31'(r_qd[W-2:0]);
                f_out.status     = ST_OK;
            end
        end else begin
            f_out.less_flag  = r_less;
            f_out.equal_flag = r_equal;
            f_out.status     = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_in.mode);
            r_ann  <= w_an[W-1];
            r_adn  <= w_ad[W-1];
            r_bnn  <= w_bn[W-1];
            r_bdn  <= w_bd[W-1];
            r_anm  <= mag_of(w_an);
            r_adm  <= mag_of(w_ad);
            r_bnm  <= mag_of(w_bn);
            r_bdm  <= mag_of(w_bd);
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                2'd0:    r_p1 <= prod;
                2'd1:    r_p2 <= prod;
                default: r_p3 <= prod;
            endcase
        end
        if (i_cmd.comb) begin
            r_nn     <= c_nn;
            r_dn     <= c_dn;
            r_nm     <= c_nm;
            r_dm     <= c_dm;
            r_x      <= c_nm;
            r_y      <= c_dm;
            r_k      <= '0;
            r_frac   <= c_frac;
            r_status <= c_err ? ST_ZERO_DEN : ST_OK;
            r_less   <= (r_mode == MODE_CMP) && !c_err && (lv < rv);
            r_equal  <= (r_mode == MODE_CMP) && !c_err && (lv == rv);
        end
        // binary gcd step
        if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= (r_x - r_y) >> 1;
            end else begin
                r_y <= (r_y - r_x) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g  <= (r_x | r_y) << r_k;
            r_qn <= r_nm;
            r_qd <= r_dm;
            r_rn <= '0;
            r_rd <= '0;
        end
        // one quotient bit per cycle for numerator and denominator
        if (i_cmd.div_step) begin
            if (tn >= gx) begin
                r_rn <= D'(tn - gx);
                r_qn <= {r_qn[D-2:0], 1'b1};
            end else begin
                r_rn <= tn[D-1:0];
                r_qn <= {r_qn[D-2:0], 1'b0};
            end
            if (td >= gx) begin
                r_rd <= D'(td - gx);
                r_qd <= {r_qd[D-2:0], 1'b1};
            end else begin
                r_rd <= td[D-1:0];
                r_qd <= {r_qd[D-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out <= f_out;
        end
    end

    assign o_out = r_out;

endmodule

### rtl/rau_checker.sv
// port-level assertions of the rational arithmetic unit and their binding
module rau_port_checker import rau_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input t_in  i_in,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_out o_out,
    input logic o_out_valid,
    input logic i_out_stall
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stalled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output item changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |->
            (o_out.result_num == '0) && (o_out.result_den == '0))
        else $error("error item carries a fraction");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.less_flag && o_out.equal_flag) &&
            (o_out.status != 2'd3))
        else $error("bad flags or status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while an item is in work");

endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (.*);
